@@ hdl/rgb_pixel_point_transform_macros.svh @@
// assertion macros for the rgb pixel point transform
`ifndef RGB_PIXEL_POINT_TRANSFORM_MACROS_SVH
`define RGB_PIXEL_POINT_TRANSFORM_MACROS_SVH

// clocked assertion, quiet while reset is held
`define RPPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also checks the reset behaviour
`define RPPT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/rppt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// shared types, constants and register codes of the pixel point transform
package rppt_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int SAMPLE_W = 16;
  localparam int GRAY_W   = 17;
  localparam int SUM_W    = SAMPLE_W + 2;
  localparam int NUM_W    = SUM_W + GRAY_W;
  localparam int DIV_W    = NUM_W - GRAY_W;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = COEF_W + SAMPLE_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int FRAC_W   = 16;
  localparam int CFG_W    = GRAY_W;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W   = 3;
  localparam int CHAN_W   = 2;
  localparam int NCH      = 3;

  // transform codes
  localparam logic [MODE_W-1:0] MODE_BINARIZE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GRAY     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ISOLATE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEPIA    = 3'd4;

  // channel codes
  localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
  localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;
  localparam logic [CHAN_W-1:0] CH_ALL   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_MAX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_MAX  = 2'd3;

  localparam logic [SAMPLE_W-1:0] INPUT_MAX_RST = 16'd255;
  localparam logic [GRAY_W-1:0]   GRAY_MAX_RST  = 17'd255;
  localparam logic [SAMPLE_W-1:0] SEPIA_LIMIT   = 16'd255;

  // sepia matrix, unsigned q0.16, rows are red, green, blue outputs
  localparam logic [COEF_W-1:0] SEPIA_Q16 [NCH][NCH] = '{
    '{16'd25756, 16'd50397, 16'd12386},
    '{16'd22872, 16'd44958, 16'd11010},
    '{16'd17826, 16'd34996, 16'd8585}
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] input_max;
    logic [GRAY_W-1:0]   gray_max;
  } cfg_t;

  // result fields that ride alongside the divider
  typedef struct packed {
    rgb_t rgb;
    logic bin_bit;
    logic gray_sel;
  } side_t;

  // divider stage contents: lq holds numerator bits still to shift in at
  // the top and quotient bits shifted in at the bottom
  typedef struct packed {
    logic [DIV_W-1:0]  rem;
    logic [GRAY_W-1:0] lq;
    logic [DIV_W-1:0]  divisor;
    logic              ovf;
    side_t             side;
  } div_t;

endpackage
`default_nettype wire

@@ hdl/rppt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// front stages: channel sum, sepia products, sepia sums, gray numerator and divider seed
module rppt_front #(
  parameter int SAMPLE_BITS = rppt_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rppt_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  input  wire rppt_pkg::rgb_t in_pix,
  output logic               ready_up,
  input  wire logic          down_ready,
  output logic               out_valid,
  output rppt_pkg::div_t     out_data
);

  localparam logic [rppt_pkg::SAMPLE_W-1:0] SMASK =
    rppt_pkg::SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);

  logic [rppt_pkg::SAMPLE_W-1:0] px [rppt_pkg::NCH];

  // stage a
  logic                        va_r;
  logic [rppt_pkg::SUM_W-1:0]  sum_a_r, sum_a_nxt;
  logic [rppt_pkg::PROD_W-1:0] prod_a_r [rppt_pkg::NCH][rppt_pkg::NCH];
  logic [rppt_pkg::PROD_W-1:0] prod_a_nxt [rppt_pkg::NCH][rppt_pkg::NCH];
  logic [rppt_pkg::SAMPLE_W-1:0] sel_a_nxt [rppt_pkg::NCH];
  rppt_pkg::rgb_t              rgb_a_r;

  // stage b
  logic                        vb_r;
  logic [rppt_pkg::NUM_W-1:0]  num_b_r, num_b_nxt;
  logic [rppt_pkg::DIV_W-1:0]  div_b_r, div_b_nxt;
  rppt_pkg::side_t             side_b_r, side_b_nxt;
  logic [rppt_pkg::ACC_W-1:0]  acc [rppt_pkg::NCH];
  logic [rppt_pkg::ACC_W-rppt_pkg::FRAC_W-1:0] sh [rppt_pkg::NCH];
  logic [rppt_pkg::SAMPLE_W-1:0] sep [rppt_pkg::NCH];

  // stage c
  logic                        vc_r;
  rppt_pkg::div_t              dc_r, dc_nxt;

  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c    = !vc_r || down_ready;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign ready_up = rdy_a;

  assign px[0] = in_pix.red   & SMASK;
  assign px[1] = in_pix.green & SMASK;
  assign px[2] = in_pix.blue  & SMASK;

  always_comb begin
    sum_a_nxt = rppt_pkg::SUM_W'(px[0]) + rppt_pkg::SUM_W'(px[1]) +
                rppt_pkg::SUM_W'(px[2]);
    for (int c = 0; c < rppt_pkg::NCH; c++) begin
      for (int k = 0; k < rppt_pkg::NCH; k++) begin
        prod_a_nxt[c][k] = rppt_pkg::PROD_W'(rppt_pkg::SEPIA_Q16[c][k]) *
                           rppt_pkg::PROD_W'(px[k]);
      end
      case (cfg.mode)
        rppt_pkg::MODE_ISOLATE: begin
          sel_a_nxt[c] = (cfg.chan == rppt_pkg::CH_ALL ||
                          cfg.chan == rppt_pkg::CHAN_W'(c)) ? px[c] : '0;
        end
        rppt_pkg::MODE_REMOVE: begin
          sel_a_nxt[c] = (cfg.chan == rppt_pkg::CHAN_W'(c)) ? '0 : px[c];
        end
        default: begin
          sel_a_nxt[c] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (rdy_a) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      sum_a_r  <= sum_a_nxt;
      prod_a_r <= prod_a_nxt;
      rgb_a_r  <= '{red: sel_a_nxt[0], green: sel_a_nxt[1], blue: sel_a_nxt[2]};
    end
  end

  // sepia sums with truncation and clamp, gray numerator and divisor
  always_comb begin
    for (int c = 0; c < rppt_pkg::NCH; c++) begin
      acc[c] = rppt_pkg::ACC_W'(prod_a_r[c][0]) + rppt_pkg::ACC_W'(prod_a_r[c][1]) +
               rppt_pkg::ACC_W'(prod_a_r[c][2]);
      sh[c]  = acc[c][rppt_pkg::ACC_W-1:rppt_pkg::FRAC_W];
      sep[c] = (sh[c] > (rppt_pkg::ACC_W-rppt_pkg::FRAC_W)'(rppt_pkg::SEPIA_LIMIT)) ?
               rppt_pkg::SEPIA_LIMIT : rppt_pkg::SAMPLE_W'(sh[c]);
    end
    num_b_nxt = rppt_pkg::NUM_W'(sum_a_r) * rppt_pkg::NUM_W'(cfg.gray_max);
    div_b_nxt = rppt_pkg::DIV_W'(cfg.input_max) +
                rppt_pkg::DIV_W'({cfg.input_max, 1'b0});
    side_b_nxt.rgb = (cfg.mode == rppt_pkg::MODE_SEPIA) ?
                     rppt_pkg::rgb_t'{red: sep[0], green: sep[1], blue: sep[2]} :
                     rgb_a_r;
    side_b_nxt.bin_bit  = (cfg.mode == rppt_pkg::MODE_BINARIZE) &&
                          ({sum_a_r, 1'b0} < {1'b0, div_b_nxt});
    side_b_nxt.gray_sel = (cfg.mode == rppt_pkg::MODE_GRAY) && (cfg.input_max != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (rdy_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      num_b_r  <= num_b_nxt;
      div_b_r  <= div_b_nxt;
      side_b_r <= side_b_nxt;
    end
  end

  // quotient overflow check, divider seed
  always_comb begin
    dc_nxt.rem     = num_b_r[rppt_pkg::NUM_W-1:rppt_pkg::GRAY_W];
    dc_nxt.lq      = num_b_r[rppt_pkg::GRAY_W-1:0];
    dc_nxt.divisor = div_b_r;
    dc_nxt.ovf     = (num_b_r[rppt_pkg::NUM_W-1:rppt_pkg::GRAY_W] >= div_b_r);
    dc_nxt.side    = side_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (rdy_c) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      dc_r <= dc_nxt;
    end
  end

  assign out_valid = vc_r;
  assign out_data  = dc_r;

endmodule
`default_nettype wire

@@ hdl/rppt_div_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// one restoring divider step: one quotient bit per stage
module rppt_div_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire rppt_pkg::div_t in_data,
  output logic                ready_up,
  input  wire logic           down_ready,
  output logic                out_valid,
  output rppt_pkg::div_t      out_data
);

  logic                       v_r;
  rppt_pkg::div_t             d_r, d_nxt;
  logic [rppt_pkg::DIV_W:0]   trial;
  logic                       fits;

  assign ready_up = !v_r || down_ready;

  always_comb begin
    trial = {in_data.rem, in_data.lq[rppt_pkg::GRAY_W-1]};
    fits  = (trial >= {1'b0, in_data.divisor});
    d_nxt = in_data;
    d_nxt.rem = fits ? rppt_pkg::DIV_W'(trial - {1'b0, in_data.divisor}) :
                trial[rppt_pkg::DIV_W-1:0];
    d_nxt.lq  = {in_data.lq[rppt_pkg::GRAY_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_up) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule
`default_nettype wire

@@ hdl/rgb_pixel_point_transform.sv @@
`timescale 1ns / 1ps
`default_nettype none
// top level of the rgb pixel point transform pipeline
//
//  port group  dir  handshake          beat contents
//  in_         in   in_valid/in_stall  red_in, green_in, blue_in samples
//  out_        out  out_valid/out_stall red_out, green_out, blue_out, gray_out
//  cfg_        in   cfg_we             cfg_index selects register, cfg_data value
//
//  one pixel per clock sustained while out_stall is low; a result passes through
//  21 register stages: three front stages, 17 divider steps and one output
//  register; the latency is set by the grayscale quotient, one bit per divider
//  stage
//  synchronous active-low reset clears every valid bit and loads the
//  register defaults (mode binarize, channel red, both maxima 255)
//  a stall only holds stages that carry a beat, so bubbles close up and
//  the input keeps taking beats while a finished result waits at the output
module rgb_pixel_point_transform #(
  parameter int SAMPLE_BITS = rppt_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [rppt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rppt_pkg::CFG_W-1:0]        cfg_data,
  // pixel input
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [rppt_pkg::SAMPLE_W-1:0]     in_red_in,
  input  wire logic [rppt_pkg::SAMPLE_W-1:0]     in_green_in,
  input  wire logic [rppt_pkg::SAMPLE_W-1:0]     in_blue_in,
  // result output
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [rppt_pkg::SAMPLE_W-1:0]          out_red_out,
  output logic [rppt_pkg::SAMPLE_W-1:0]          out_green_out,
  output logic [rppt_pkg::SAMPLE_W-1:0]          out_blue_out,
  output logic [rppt_pkg::GRAY_W-1:0]            out_gray_out
);

  // configuration registers
  logic [rppt_pkg::MODE_W-1:0]   mode_r;
  logic [rppt_pkg::CHAN_W-1:0]   chan_r;
  logic [rppt_pkg::SAMPLE_W-1:0] input_max_r;
  logic [rppt_pkg::GRAY_W-1:0]   gray_max_r;
  rppt_pkg::cfg_t                cfg;

  // divider chain: index 0 is the front's output, the last one feeds the
  // output register
  logic           dv   [rppt_pkg::GRAY_W+1];
  rppt_pkg::div_t dd   [rppt_pkg::GRAY_W+1];
  logic           drdy [rppt_pkg::GRAY_W+1];

  logic           front_rdy;
  rppt_pkg::rgb_t in_pix;
  rppt_pkg::div_t last;

  // output register
  logic                          out_valid_r;
  rppt_pkg::rgb_t                out_rgb_r, out_rgb_nxt;
  logic [rppt_pkg::GRAY_W-1:0]   out_gray_r, out_gray_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= rppt_pkg::MODE_BINARIZE;
      chan_r      <= rppt_pkg::CH_RED;
      input_max_r <= rppt_pkg::INPUT_MAX_RST;
      gray_max_r  <= rppt_pkg::GRAY_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rppt_pkg::REG_MODE:      mode_r      <= cfg_data[rppt_pkg::MODE_W-1:0];
        rppt_pkg::REG_CHANNEL:   chan_r      <= cfg_data[rppt_pkg::CHAN_W-1:0];
        rppt_pkg::REG_INPUT_MAX: input_max_r <= cfg_data[rppt_pkg::SAMPLE_W-1:0];
        rppt_pkg::REG_GRAY_MAX:  gray_max_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = '{mode: mode_r, chan: chan_r, input_max: input_max_r,
                 gray_max: gray_max_r};

  assign in_pix = '{red: in_red_in, green: in_green_in, blue: in_blue_in};

  // sums, sepia matrix and the gray numerator/divisor
  rppt_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_pix     (in_pix),
    .ready_up   (front_rdy),
    .down_ready (drdy[0]),
    .out_valid  (dv[0]),
    .out_data   (dd[0])
  );

  assign in_stall = !front_rdy;

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < rppt_pkg::GRAY_W; k++) begin : g_div
    rppt_div_stage u_step (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_valid   (dv[k]),
      .in_data    (dd[k]),
      .ready_up   (drdy[k]),
      .down_ready (drdy[k+1]),
      .out_valid  (dv[k+1]),
      .out_data   (dd[k+1])
    );
  end

  // the output register takes a beat whenever it is empty or being drained
  assign drdy[rppt_pkg::GRAY_W] = !out_valid_r || !out_stall;
  assign last = dd[rppt_pkg::GRAY_W];

  always_comb begin
    out_rgb_nxt = last.side.rgb;
    if (last.side.gray_sel) begin
      // quotient wider than the field saturates at all ones
      out_gray_nxt = last.ovf ? '1 : last.lq;
    end else begin
      out_gray_nxt = {{(rppt_pkg::GRAY_W-1){1'b0}}, last.side.bin_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (drdy[rppt_pkg::GRAY_W]) begin
      out_valid_r <= dv[rppt_pkg::GRAY_W];
    end
  end

  always_ff @(posedge clk) begin
    if (drdy[rppt_pkg::GRAY_W]) begin
      out_rgb_r  <= out_rgb_nxt;
      out_gray_r <= out_gray_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_rgb_r.red;
  assign out_green_out = out_rgb_r.green;
  assign out_blue_out  = out_rgb_r.blue;
  assign out_gray_out  = out_gray_r;

endmodule
`default_nettype wire

@@ hdl/rgb_pixel_point_transform_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// port-level checker for the pixel point transform, bound to the top level
`include "rgb_pixel_point_transform_macros.svh"
module rgb_pixel_point_transform_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           cfg_we,
  input wire logic [rppt_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [rppt_pkg::CFG_W-1:0]     cfg_data,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [rppt_pkg::SAMPLE_W-1:0]  out_red_out,
  input wire logic [rppt_pkg::SAMPLE_W-1:0]  out_green_out,
  input wire logic [rppt_pkg::SAMPLE_W-1:0]  out_blue_out,
  input wire logic [rppt_pkg::GRAY_W-1:0]    out_gray_out
);

  // shadow of the mode register, seen from the write port
  logic [rppt_pkg::MODE_W-1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rppt_pkg::MODE_BINARIZE;
    end else if (cfg_we && cfg_index == rppt_pkg::REG_MODE) begin
      mode_r <= cfg_data[rppt_pkg::MODE_W-1:0];
    end
  end

  `RPPT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped while stalled")

  `RPPT_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result beat right after reset")

  `RPPT_ASSERT(a_gray_modes, out_valid && (mode_r == rppt_pkg::MODE_BINARIZE || mode_r == rppt_pkg::MODE_GRAY) |-> out_red_out == '0 && out_green_out == '0 && out_blue_out == '0, "colour fields set in a gray mode")

  `RPPT_ASSERT(a_bin_bit, out_valid && mode_r == rppt_pkg::MODE_BINARIZE |-> out_gray_out <= 17'd1, "binarize result wider than one bit")

  `RPPT_ASSERT(a_sepia_clamp, out_valid && mode_r == rppt_pkg::MODE_SEPIA |-> out_red_out <= rppt_pkg::SEPIA_LIMIT && out_green_out <= rppt_pkg::SEPIA_LIMIT && out_blue_out <= rppt_pkg::SEPIA_LIMIT && out_gray_out == '0, "sepia result out of range")

endmodule

bind rgb_pixel_point_transform rgb_pixel_point_transform_chk u_chk (.*);
`default_nettype wire

@@ tb/sv/pixel_transform_checker.sv @@
`timescale 1ns / 1ps
// checker for the rgb pixel point transform: predicts every pixel and compares results
module pixel_transform_checker
  import rppt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_red_in,
  input  logic [SAMPLE_W-1:0]   in_green_in,
  input  logic [SAMPLE_W-1:0]   in_blue_in,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [SAMPLE_W-1:0]   out_red_out,
  input  logic [SAMPLE_W-1:0]   out_green_out,
  input  logic [SAMPLE_W-1:0]   out_blue_out,
  input  logic [GRAY_W-1:0]     out_gray_out,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  localparam int REPORT_CAP = 200;
  localparam logic [63:0] GRAY_CEIL  = 64'd131071;
  localparam logic [63:0] SHADE_CEIL = 64'd255;
  localparam logic [15:0] SEPIA_COEF [3][3] = '{
    '{16'd25756, 16'd50397, 16'd12386},
    '{16'd22872, 16'd44958, 16'd11010},
    '{16'd17826, 16'd34996, 16'd8585}
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic [GRAY_W-1:0]   gray;
  } pixel_result_t;

  logic [MODE_W-1:0]   mode_q;
  logic [CHAN_W-1:0]   chan_q;
  logic [SAMPLE_W-1:0] imax_q;
  logic [GRAY_W-1:0]   gmax_q;

  pixel_result_t expected_pixels [$];

  function automatic pixel_result_t transform_pixel(input logic [SAMPLE_W-1:0] r, g, b);
    pixel_result_t       res;
    logic [SAMPLE_W-1:0] px [3];
    logic [SAMPLE_W-1:0] shade [3];
    logic [63:0]         sum;
    logic [63:0]         quo;
    logic [63:0]         acc;
    res = '0;
    px[0] = r;
    px[1] = g;
    px[2] = b;
    for (int c = 0; c < 3; c++) shade[c] = '0;
    sum = 64'(r) + 64'(g) + 64'(b);
    case (mode_q)
      MODE_BINARIZE: res.gray = (64'd2 * sum < 64'd3 * 64'(imax_q)) ? 17'd1 : 17'd0;
      MODE_GRAY: begin
        if (imax_q != '0) begin
          quo = (sum * 64'(gmax_q)) / (64'd3 * 64'(imax_q));
          res.gray = (quo > GRAY_CEIL) ? GRAY_CEIL[GRAY_W-1:0] : quo[GRAY_W-1:0];
        end
      end
      MODE_ISOLATE: begin
        for (int c = 0; c < 3; c++)
          shade[c] = (chan_q == CH_ALL || c == int'(chan_q)) ? px[c] : '0;
      end
      MODE_REMOVE: begin
        for (int c = 0; c < 3; c++)
          shade[c] = (c == int'(chan_q)) ? '0 : px[c];
      end
      MODE_SEPIA: begin
        for (int c = 0; c < 3; c++) begin
          acc = '0;
          for (int k = 0; k < 3; k++) acc += 64'(SEPIA_COEF[c][k]) * 64'(px[k]);
          acc = acc >> 16;
          shade[c] = (acc > SHADE_CEIL) ? SHADE_CEIL[SAMPLE_W-1:0] : acc[SAMPLE_W-1:0];
        end
      end
      default: ;
    endcase
    res.red   = shade[0];
    res.green = shade[1];
    res.blue  = shade[2];
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (fail_count < REPORT_CAP) $display("%0t ns: result %0d: %s", $time, checked, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      mode_q <= MODE_BINARIZE;
      chan_q <= CH_RED;
      imax_q <= INPUT_MAX_RST;
      gmax_q <= GRAY_MAX_RST;
      expected_pixels.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:      mode_q <= cfg_data[MODE_W-1:0];
          REG_CHANNEL:   chan_q <= cfg_data[CHAN_W-1:0];
          REG_INPUT_MAX: imax_q <= cfg_data[SAMPLE_W-1:0];
          REG_GRAY_MAX:  gmax_q <= cfg_data[GRAY_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_pixels.push_back(transform_pixel(in_red_in, in_green_in, in_blue_in));
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          flag_mismatch("result with no pixel outstanding");
        end else begin
          want = expected_pixels.pop_front();
          if (out_red_out != want.red)
            flag_mismatch($sformatf("red_out %0d, expected %0d", out_red_out, want.red));
          if (out_green_out != want.green)
            flag_mismatch($sformatf("green_out %0d, expected %0d", out_green_out, want.green));
          if (out_blue_out != want.blue)
            flag_mismatch($sformatf("blue_out %0d, expected %0d", out_blue_out, want.blue));
          if (out_gray_out != want.gray)
            flag_mismatch($sformatf("gray_out %0d, expected %0d", out_gray_out, want.gray));
        end
        checked++;
      end
      pending <= expected_pixels.size();
    end
  end

endmodule

@@ tb/sv/rgb_pixel_point_transform_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the rgb pixel point transform: stimulus, idling and verdict
module rgb_pixel_point_transform_tb;
  import rppt_pkg::*;

  localparam int SETTINGS_PER_PROFILE = 6;
  localparam int PIXELS_PER_SETTING   = 53;
  localparam int DRAIN_PAUSE          = 3;   // every pixel yields a result, so drained means idle
  localparam int END_PAUSE            = 25;
  localparam int STALL_LIMIT          = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  in_red_in = '0;
  logic [SAMPLE_W-1:0]  in_green_in = '0;
  logic [SAMPLE_W-1:0]  in_blue_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SAMPLE_W-1:0]  out_red_out;
  logic [SAMPLE_W-1:0]  out_green_out;
  logic [SAMPLE_W-1:0]  out_blue_out;
  logic [GRAY_W-1:0]    out_gray_out;

  int fail_count;
  int pending;
  int checked;

  // idling odds in percent, changed per profile
  int tx_idle_pct  = 9;
  int rx_stall_pct = 80;

  int sent_pixels      = 0;
  int settings_applied = 0;
  int quiet_cycles     = 0;

  // input maximum currently programmed, steers the sample picker
  logic [SAMPLE_W-1:0] cur_imax = INPUT_MAX_RST;

  always #10 clk = ~clk;

  rgb_pixel_point_transform uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .out_gray_out (out_gray_out)
  );

  pixel_transform_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .out_gray_out (out_gray_out),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < rx_stall_pct);

  // watchdog: ends the run if neither channel nor the register port moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // one pixel beat: optional idle cycles first, then hold until taken
  task automatic send_pixel(input logic [SAMPLE_W-1:0] r, g, b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_pixels++;
  endtask

  // wait for the pipe to drain, then program all four registers back to back
  task automatic apply_setting(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] chan,
                               input logic [SAMPLE_W-1:0] imax, input logic [GRAY_W-1:0] gmax);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data <= CFG_W'(mode);
    @(posedge clk);
    cfg_index <= REG_CHANNEL;
    cfg_data <= CFG_W'(chan);
    @(posedge clk);
    cfg_index <= REG_INPUT_MAX;
    cfg_data <= CFG_W'(imax);
    @(posedge clk);
    cfg_index <= REG_GRAY_MAX;
    cfg_data <= CFG_W'(gmax);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_imax = imax;
    settings_applied++;
  endtask

  // mostly in-range samples so the threshold and the quotient see both sides,
  // with the odd full-scale or out-of-range value mixed in
  function automatic logic [SAMPLE_W-1:0] random_sample(input logic [SAMPLE_W-1:0] imax);
    case ($urandom_range(0, 9))
      6:       return '0;
      7:       return '1;
      8:       return imax;
      9:       return SAMPLE_W'($urandom_range(0, 65535));
      default: return SAMPLE_W'($urandom_range(0, imax));
    endcase
  endfunction

  // random register setting, weighted towards the five real transforms
  task automatic pick_setting();
    int                  sel;
    logic [MODE_W-1:0]   mode;
    logic [SAMPLE_W-1:0] imax;
    logic [GRAY_W-1:0]   gmax;
    sel = $urandom_range(0, 19);
    if (sel < 17) mode = MODE_W'(sel % (int'(MODE_SEPIA) + 1));
    else          mode = MODE_W'(int'(MODE_SEPIA) + 1 + sel - 17);
    case ($urandom_range(0, 5))
      0:       imax = '0;
      1:       imax = 16'd1;
      2:       imax = INPUT_MAX_RST;
      3:       imax = '1;
      default: imax = SAMPLE_W'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 6))
      0:       gmax = '0;
      1:       gmax = 17'd1;
      2:       gmax = GRAY_MAX_RST;
      3:       gmax = 17'd65536;
      4:       gmax = '1;
      default: gmax = GRAY_W'($urandom_range(1, 131071));
    endcase
    apply_setting(mode, CHAN_W'($urandom_range(0, 3)), imax, gmax);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, first against the reset values: binarize with input max 255,
    // threshold sits between sums 382 and 383
    send_pixel(16'd0, 16'd0, 16'd0);
    send_pixel(16'd127, 16'd127, 16'd128);
    send_pixel(16'd128, 16'd127, 16'd128);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);

    // grayscale at default scale
    apply_setting(MODE_GRAY, CH_RED, INPUT_MAX_RST, GRAY_MAX_RST);
    send_pixel(16'd255, 16'd255, 16'd255);
    send_pixel(16'hFFFF, 16'd0, 16'hFFFF);
    // samples far above input max: quotient clips at the field's top
    apply_setting(MODE_GRAY, CH_RED, 16'd1, 17'h1FFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'd1, 16'd0, 16'd0);
    // zero gray maximum
    apply_setting(MODE_GRAY, CH_RED, 16'd1, 17'd0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    // zero input max: both grey transforms give zero
    apply_setting(MODE_GRAY, CH_RED, 16'd0, 17'd65536);
    send_pixel(16'd100, 16'd0, 16'd0);
    apply_setting(MODE_BINARIZE, CH_RED, 16'd0, 17'd65536);
    send_pixel(16'd0, 16'd0, 16'd0);

    // isolate and remove on every channel, the all-channels code included
    for (int ch = int'(CH_RED); ch <= int'(CH_ALL); ch++) begin
      apply_setting(MODE_ISOLATE, CHAN_W'(ch), 16'hFFFF, 17'd1);
      send_pixel(16'h1234, 16'hABCD, 16'hFFFF);
    end
    for (int ch = int'(CH_RED); ch <= int'(CH_ALL); ch++) begin
      apply_setting(MODE_REMOVE, CHAN_W'(ch), 16'hFFFF, 17'd1);
      send_pixel(16'h1234, 16'hABCD, 16'hFFFF);
    end

    // sepia: saturating, partly saturating and mid-range pixels
    apply_setting(MODE_SEPIA, CH_BLUE, 16'hFFFF, 17'd65536);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'd255, 16'd255, 16'd255);
    send_pixel(16'd100, 16'd50, 16'd25);

    // unused mode codes give an all-zero result
    for (int m = int'(MODE_SEPIA) + 1; m < (1 << MODE_W); m++) begin
      apply_setting(MODE_W'(m), CH_GREEN, INPUT_MAX_RST, GRAY_MAX_RST);
      send_pixel(16'hFFFF, 16'h00FF, 16'h8001);
    end

    // random part: three idling profiles, each over several register settings
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          tx_idle_pct  = 9;
          rx_stall_pct = 80;
        end
        1: begin
          tx_idle_pct  = 80;
          rx_stall_pct = 9;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      for (int s = 0; s < SETTINGS_PER_PROFILE; s++) begin
        pick_setting();
        repeat (PIXELS_PER_SETTING)
          send_pixel(random_sample(cur_imax), random_sample(cur_imax),
                     random_sample(cur_imax));
      end
    end

    // drain, then give stray results a chance to show up
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (END_PAUSE) @(posedge clk);

    $display("%0d pixels over %0d register settings (all five transforms, unused modes,",
             sent_pixels, settings_applied);
    $display("  zero and full-scale maxima, three idling profiles); %0d results compared",
             checked);
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ rgb_pixel_point_transform.f @@
+incdir+hdl
hdl/rppt_pkg.sv
hdl/rppt_front.sv
hdl/rppt_div_stage.sv
hdl/rgb_pixel_point_transform.sv
hdl/rgb_pixel_point_transform_chk.sv
tb/sv/pixel_transform_checker.sv
tb/sv/rgb_pixel_point_transform_tb.sv
